@@ design/stm_pkg.sv @@
// ----------------------------------------------------------------------------
// stm_pkg
// Shared types, register codes and phase tables of the trapezoidal stepper
// move sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stm_pkg;

  // field widths
  localparam int STEP_W     = 10;
  localparam int DLY_W      = 8;
  localparam int PROD_W     = 2 * DLY_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MOVE_STEPS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DELAY  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DELAY  = 2'd2;

  // register reset values
  localparam logic [STEP_W-1:0] MOVE_STEPS_RST = 10'd100;
  localparam logic [DLY_W-1:0]  MIN_DELAY_RST  = 8'd5;
  localparam logic [DLY_W-1:0]  MAX_DELAY_RST  = 8'd20;

  // op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the accepted word
    logic eval;    // apply the word to the move state
    logic prep;    // pick ramp segment and multiplier operands
    logic mul_go;  // multiply and start the divider
    logic fin;     // load the step delay
  } stm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic take_step;  // the word being evaluated takes a step
    logic div_busy;   // divider still iterating
  } stm_stat_t;

  // coil drive byte of a phase
  function automatic logic [7:0] coil_of(input logic [1:0] ph);
    logic [7:0] c;
    case (ph)
      2'd0:    c = 8'h30;
      2'd1:    c = 8'h06;
      2'd2:    c = 8'h28;
      default: c = 8'h05;
    endcase
    return c;
  endfunction

  // one-hot marker of the phase being left
  function automatic logic [3:0] marker_of(input logic [1:0] ph);
    logic [3:0] m;
    case (ph)
      2'd0:    m = 4'h2;
      2'd1:    m = 4'h4;
      2'd2:    m = 4'h8;
      default: m = 4'h1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ design/stm_div.sv @@
// ----------------------------------------------------------------------------
// stm_div
// Restoring divider, one quotient bit per cycle, for the ramp delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stm_div
  import stm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [DLY_W-1:0]  divisor,
  output logic                   busy,
  output logic [DLY_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] quo_r;
  logic [DLY_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [DLY_W:0]    trial;
  logic              fits;

  // trial subtract of the next partial remainder
  assign trial = {rem_r, quo_r[PROD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(PROD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[PROD_W-2:0], fits};
      if (fits) begin
        rem_r <= DLY_W'(trial - {1'b0, divisor});
      end else begin
        rem_r <= trial[DLY_W-1:0];
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r[DLY_W-1:0];

endmodule

`default_nettype wire

@@ design/stm_dp.sv @@
// ----------------------------------------------------------------------------
// stm_dp
// Move datapath: settings registers, phase and step state, trapezoid
// profile and the step delay divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stm_dp
  import stm_pkg::*;
#(
  parameter int MAX_MOVE_STEPS = 1023
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  item_op,
  input  wire logic                  item_dir,
  input  wire logic [1:0]            item_phase,
  input  wire stm_cmd_t              cmd,
  output stm_stat_t                  stat,
  output logic [7:0]                 coil_pattern,
  output logic [3:0]                 phase_marker,
  output logic [1:0]                 phase,
  output logic                       busy_res,
  output logic                       done_res
);

  localparam int CMP_W = (STEP_W > 17) ? STEP_W + 1 : 17;

  typedef enum logic [1:0] {SEG_UP, SEG_FLAT, SEG_DOWN} seg_t;

  // settings
  logic [STEP_W-1:0] move_steps_r;
  logic [DLY_W-1:0]  min_delay_r;
  logic [DLY_W-1:0]  max_delay_r;

  // latched word
  logic       op_r;
  logic       dir_r;
  logic [1:0] sp_r;

  // move state
  logic [1:0]        cur_phase_r;
  logic [STEP_W-1:0] step_index_r;
  logic [DLY_W-1:0]  wait_count_r;
  logic              moving_r;
  logic              backward_r;
  logic [7:0]        drive_byte_r;
  logic [3:0]        marker_bits_r;
  logic              done_r;

  // profile operands
  seg_t             seg_r;
  logic [DLY_W-1:0] mul_a_r;
  logic [DLY_W-1:0] diff_r;
  logic [DLY_W-1:0] hi_r;
  logic [DLY_W-1:0] lo_r;
  logic [DLY_W-1:0] ramp_r;

  logic [STEP_W-1:0] steps_s;
  logic [DLY_W-1:0]  ramp_s;
  logic [DLY_W-1:0]  lo_s;
  logic [DLY_W-1:0]  diff_s;
  logic [STEP_W-1:0] flat_end_s;
  logic [STEP_W-1:0] k_full_s;
  logic [DLY_W-1:0]  k_s;
  seg_t              seg_s;
  logic [DLY_W-1:0]  mul_a_s;

  logic              start_ok;
  logic              tick_ok;
  logic [DLY_W-1:0]  wait_dec;
  logic              wait_zero;
  logic              last_step;
  logic              steps_zero;
  logic [1:0]        left_s;
  logic              back_s;
  logic [1:0]        next_s;
  logic              take_s;

  logic [PROD_W-1:0] prod_s;
  logic              div_busy;
  logic [DLY_W-1:0]  quo;
  logic [DLY_W-1:0]  delay_raw;
  logic [DLY_W-1:0]  delay_s;

  // settings write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_steps_r <= MOVE_STEPS_RST;
      min_delay_r  <= MIN_DELAY_RST;
      max_delay_r  <= MAX_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MOVE_STEPS: move_steps_r <= cfg_data;
        REG_MIN_DELAY:  min_delay_r  <= cfg_data[DLY_W-1:0];
        REG_MAX_DELAY:  max_delay_r  <= cfg_data[DLY_W-1:0];
        default:        ;
      endcase
    end
  end

  // step count saturated to the build limit
  always_comb begin
    if ({{(CMP_W-STEP_W){1'b0}}, move_steps_r} > CMP_W'(MAX_MOVE_STEPS)) begin
      steps_s = STEP_W'(MAX_MOVE_STEPS);
    end else begin
      steps_s = move_steps_r;
    end
  end

  // trapezoid segment of the current step
  assign ramp_s     = steps_s[STEP_W-1:2];
  assign lo_s       = (min_delay_r > max_delay_r) ? max_delay_r : min_delay_r;
  assign diff_s     = max_delay_r - lo_s;
  assign flat_end_s = steps_s - {2'b00, ramp_s};
  assign k_full_s   = step_index_r - flat_end_s;
  assign k_s        = (k_full_s > {2'b00, ramp_s}) ? ramp_s : k_full_s[DLY_W-1:0];

  always_comb begin
    if (step_index_r < {2'b00, ramp_s}) begin
      seg_s   = SEG_UP;
      mul_a_s = step_index_r[DLY_W-1:0];
    end else if (step_index_r < flat_end_s || ramp_s == '0) begin
      seg_s   = SEG_FLAT;
      mul_a_s = '0;
    end else begin
      seg_s   = SEG_DOWN;
      mul_a_s = k_s;
    end
  end

  // effect of the latched word
  assign start_ok   = (op_r == OP_START) && !moving_r;
  assign tick_ok    = (op_r == OP_TICK) && moving_r;
  assign wait_dec   = (wait_count_r != '0) ? wait_count_r - 1'b1 : wait_count_r;
  assign wait_zero  = (wait_dec == '0);
  assign last_step  = ({1'b0, step_index_r} + 1'b1) >= {1'b0, steps_s};
  assign steps_zero = (steps_s == '0);
  assign left_s     = start_ok ? sp_r : cur_phase_r;
  assign back_s     = start_ok ? dir_r : backward_r;
  assign next_s     = back_s ? left_s - 1'b1 : left_s + 1'b1;
  assign take_s     = (start_ok && !steps_zero) || (tick_ok && wait_zero && !last_step);

  // word latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= item_op;
      dir_r <= item_dir;
      sp_r  <= item_phase;
    end
  end

  // move state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_phase_r   <= '0;
      step_index_r  <= '0;
      wait_count_r  <= '0;
      moving_r      <= 1'b0;
      backward_r    <= 1'b0;
      drive_byte_r  <= '0;
      marker_bits_r <= '0;
      done_r        <= 1'b0;
    end else if (cmd.eval) begin
      done_r <= (start_ok && steps_zero) || (tick_ok && wait_zero && last_step);
      if (start_ok) begin
        cur_phase_r  <= sp_r;
        backward_r   <= dir_r;
        step_index_r <= '0;
        moving_r     <= !steps_zero;
        if (steps_zero) begin
          wait_count_r <= '0;
        end
      end
      if (tick_ok) begin
        wait_count_r <= wait_dec;
        if (wait_zero) begin
          if (last_step) begin
            moving_r <= 1'b0;
          end else begin
            step_index_r <= step_index_r + 1'b1;
          end
        end
      end
      if (take_s) begin
        marker_bits_r <= marker_of(left_s);
        drive_byte_r  <= coil_of(next_s);
        cur_phase_r   <= next_s;
      end
    end else if (cmd.fin) begin
      wait_count_r <= delay_s;
    end
  end

  // profile operands
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      seg_r   <= seg_s;
      mul_a_r <= mul_a_s;
      diff_r  <= diff_s;
      hi_r    <= max_delay_r;
      lo_r    <= lo_s;
      ramp_r  <= ramp_s;
    end
  end

  // ramp product feeds the divider register directly
  assign prod_s = {{DLY_W{1'b0}}, mul_a_r} * {{DLY_W{1'b0}}, diff_r};

  stm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mul_go),
    .dividend (prod_s),
    .divisor  (ramp_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  // step delay from the segment
  always_comb begin
    case (seg_r)
      SEG_UP:   delay_raw = hi_r - quo;
      SEG_DOWN: delay_raw = lo_r + quo;
      default:  delay_raw = lo_r;
    endcase
  end

  assign delay_s = (delay_raw == '0) ? DLY_W'(1) : delay_raw;

  assign stat.take_step = take_s;
  assign stat.div_busy  = div_busy;

  assign coil_pattern = drive_byte_r;
  assign phase_marker = marker_bits_r;
  assign phase        = cur_phase_r;
  assign busy_res     = moving_r;
  assign done_res     = done_r;

endmodule

`default_nettype wire

@@ design/stm_ctrl.sv @@
// ----------------------------------------------------------------------------
// stm_ctrl
// Sequencer: takes one word, applies it, runs the delay calculation when a
// step is taken, and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stm_ctrl
  import stm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      out_free,
  input  wire stm_stat_t stat,
  output stm_cmd_t       cmd,
  output logic           emit
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_PREP, S_MUL, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_EVAL;
        S_EVAL: state_r <= stat.take_step ? S_PREP : S_OUT;
        S_PREP: state_r <= S_MUL;
        S_MUL:  state_r <= S_DIV;
        S_DIV:  if (!stat.div_busy) state_r <= S_FIN;
        S_FIN:  state_r <= S_OUT;
        S_OUT:  if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // command decode
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.eval   = (state_r == S_EVAL);
  assign cmd.prep   = (state_r == S_PREP);
  assign cmd.mul_go = (state_r == S_MUL);
  assign cmd.fin    = (state_r == S_FIN);
  assign emit       = (state_r == S_OUT) && out_free;

endmodule

`default_nettype wire

@@ design/stepper_trapezoid_move.sv @@
// ----------------------------------------------------------------------------
// stepper_trapezoid_move
// Full-step stepper move sequencer with a trapezoidal speed profile.
// ----------------------------------------------------------------------------
// One word is handled at a time and every word returns exactly one result
// word. A word that takes no step (ignored start, start of an empty move,
// tick while idle, tick inside a step, the tick that ends the move) goes
// from evaluation straight to the output state. A word that takes a step
// also passes the prep, multiply, divide and finish states, where it
// waits on the restoring divider, one quotient bit per cycle, to turn the
// ramp position into the next step's tick count. The result sits in an
// output register, so the next word can be taken while it waits. A stalled
// result holds a finished word back from the output register. Settings are
// to be written on the cfg port by the user only while the block holds no
// word; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module stepper_trapezoid_move
  import stm_pkg::*;
#(
  parameter int MAX_MOVE_STEPS = 1023
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input words
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [0] direction, [2:1] start_phase
  input  wire logic                  in_tuser,   // [0] op
  // result words
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [7:0] coil_pattern, [11:8] phase_marker,
                                                 // [13:12] phase, [14] busy_res
  output logic                       out_tlast,  // done_res
  // settings write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  stm_cmd_t  cmd;
  stm_stat_t stat;
  logic      emit;
  logic      out_free;

  logic [7:0] coil_pattern;
  logic [3:0] phase_marker;
  logic [1:0] phase;
  logic       busy_res;
  logic       done_res;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tlast_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  stm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .emit     (emit)
  );

  stm_dp #(
    .MAX_MOVE_STEPS (MAX_MOVE_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .item_op      (in_tuser),
    .item_dir     (in_tdata[0]),
    .item_phase   (in_tdata[2:1]),
    .cmd          (cmd),
    .stat         (stat),
    .coil_pattern (coil_pattern),
    .phase_marker (phase_marker),
    .phase        (phase),
    .busy_res     (busy_res),
    .done_res     (done_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= {1'b0, busy_res, phase, phase_marker, coil_pattern};
      out_tlast_r <= done_res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

@@ design/stm_checker.sv @@
// ----------------------------------------------------------------------------
// stm_checker
// Port-level checks of the stepper move sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stm_checker
  import stm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one word at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is in work");

  // the finishing word never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[14])
    else $error("done with busy set");

  // phase marker is one-hot or clear
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[11:8]))
    else $error("phase marker not one-hot");

endmodule

bind stepper_trapezoid_move stm_checker u_stm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
